>>> src/fatlc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT32 layout compute package
// Shared constants and the result type of the refinement pass unit.
// ----------------------------------------------------------------------------
package fatlc_pkg;

	// Status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SMALL = 2'd1;
	localparam logic [1:0] ST_LARGE = 2'd2;

	// Default pass limit
	localparam int MAX_PASSES_DEF = 64;

	// Field widths
	localparam int SPF_W  = 26;
	localparam int CLUS_W = 32;
	localparam int META_W = SPF_W + 1;

	// Layout constants
	localparam logic [31:0] DEFAULT_START    = 32'd2048;
	localparam logic [32:0] MIN_PART_SECTORS = 33'd131072;
	localparam logic [META_W-1:0] RESV_SECTORS = META_W'(32);
	localparam logic [31:0] MIN_CLUSTERS     = 32'd65525;
	localparam logic [31:0] MAX_CLUSTERS     = 32'h0fff_fff5;

	// Cluster size thresholds in sectors (bytes / 512)
	localparam logic [31:0] THR_SPC1  = 32'd532480;
	localparam logic [31:0] THR_SPC8  = 32'd16777216;
	localparam logic [31:0] THR_SPC16 = 32'd33554432;
	localparam logic [31:0] THR_SPC32 = 32'd67108864;

	// Sectors per cluster as a shift amount
	localparam logic [2:0] SH_SPC1  = 3'd0;
	localparam logic [2:0] SH_SPC8  = 3'd3;
	localparam logic [2:0] SH_SPC16 = 3'd4;
	localparam logic [2:0] SH_SPC32 = 3'd5;
	localparam logic [2:0] SH_SPC64 = 3'd6;

	// Result of one refinement pass
	typedef struct packed {
		logic              meta_ovf;
		logic              same;
		logic [CLUS_W-1:0] clusters;
		logic [SPF_W-1:0]  spf_next;
	} pass_res_t;

endpackage

>>> src/fatlc_pass_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT32 layout refinement pass unit
// One fixed-point pass: metadata size, cluster count and the next FAT size.
// ----------------------------------------------------------------------------
module fatlc_pass_unit (
	input  logic [31:0]                  total,
	input  logic [2:0]                   spc_shift,
	input  logic [fatlc_pkg::SPF_W-1:0]  spf,
	output fatlc_pkg::pass_res_t         res
);

	logic [fatlc_pkg::META_W-1:0] meta;
	logic [31:0]                  diff;
	logic [31:0]                  clus;
	logic [34:0]                  entry_bytes;

	// Reserved sectors plus two FAT copies, then the cluster count
	always_comb begin
		meta      = fatlc_pkg::RESV_SECTORS + {spf, 1'b0};
		diff      = total - 32'(meta);
		clus      = diff >> spc_shift;
		// Four bytes per entry for clusters plus two, rounded up to sectors
		entry_bytes = {1'b0, clus, 2'b00} + 35'd519;
		res.meta_ovf = ({1'b0, total} <= 33'(meta));
		res.clusters = clus;
		res.spf_next = entry_bytes[34:9];
		res.same     = (entry_bytes[34:9] == spf);
	end

endmodule

>>> src/fat32_layout_compute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT32 layout compute
// Works out the FAT32 layout for a medium of a given size in bytes.
// ----------------------------------------------------------------------------
// Sequence: start captures the item; the check state pulses done on a size error, else
// N passes (1 to MAX_PASSES) run one pass per cycle through the shared pass unit, and
// done pulses on metadata overflow or from the final state; busy is high meanwhile.
// A new item is accepted in the cycle its predecessor's result is shown.
// Results are strobed for one cycle and cannot be stalled.
// Reset clears the sequencer and sets the partition start register to 2048.
module fat32_layout_compute #(
	parameter int MAX_PASSES = fatlc_pkg::MAX_PASSES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] target_bytes,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output logic        done,
	output logic [1:0]  status,
	output logic [6:0]  cluster_sectors,
	output logic [31:0] fat_sectors,
	output logic [31:0] part_sectors,
	output logic [31:0] cluster_count,
	output logic [31:0] start_sector
);

	localparam int PASS_W = $clog2(MAX_PASSES + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_ITER,
		S_FINAL
	} state_t;

	state_t                        state_q;
	logic [31:0]                   pstart_q;
	logic [63:0]                   target_q;
	logic [31:0]                   start_q;
	logic [31:0]                   total_q;
	logic [2:0]                    shift_q;
	logic [fatlc_pkg::SPF_W-1:0]   spf_q;
	logic [fatlc_pkg::CLUS_W-1:0]  clus_q;
	logic [PASS_W-1:0]             pass_q;
	logic                          done_q;
	logic [1:0]                    status_q;
	logic [6:0]                    spc_q;
	logic [31:0]                   fat_q;
	logic [31:0]                   part_q;
	logic [31:0]                   dclus_q;
	logic [31:0]                   sstart_q;

	logic [32:0]                   lim_sec;
	logic [63:0]                   lim_bytes;
	logic                          too_small;
	logic [54:0]                   total64;
	logic [54:0]                   diff55;
	logic                          too_large;
	logic [2:0]                    shift_d;
	fatlc_pkg::pass_res_t          pres;

	// Configuration register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pstart_q <= fatlc_pkg::DEFAULT_START;
		end else if (cfg_valid && cfg_ready) begin
			pstart_q <= cfg_data;
		end
	end

	// Size checks and cluster size selection for the captured item
	always_comb begin
		lim_sec   = {1'b0, start_q} + fatlc_pkg::MIN_PART_SECTORS;
		lim_bytes = {22'd0, lim_sec, 9'd0};
		too_small = (target_q < lim_bytes);
		total64   = target_q[63:9];
		diff55    = total64 - {23'd0, start_q};
		too_large = (total64 <= {23'd0, start_q}) || (|diff55[54:32]);
		if (diff55[31:0] <= fatlc_pkg::THR_SPC1) begin
			shift_d = fatlc_pkg::SH_SPC1;
		end else if (diff55[31:0] <= fatlc_pkg::THR_SPC8) begin
			shift_d = fatlc_pkg::SH_SPC8;
		end else if (diff55[31:0] <= fatlc_pkg::THR_SPC16) begin
			shift_d = fatlc_pkg::SH_SPC16;
		end else if (diff55[31:0] <= fatlc_pkg::THR_SPC32) begin
			shift_d = fatlc_pkg::SH_SPC32;
		end else begin
			shift_d = fatlc_pkg::SH_SPC64;
		end
	end

	// Shared refinement pass unit
	fatlc_pass_unit u_pass (
		.total     (total_q),
		.spc_shift (shift_q),
		.spf       (spf_q),
		.res       (pres)
	);

	// Sequencer with the registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			status_q <= fatlc_pkg::ST_OK;
			pass_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						target_q <= target_bytes;
						start_q  <= (pstart_q != 32'd0) ? pstart_q : fatlc_pkg::DEFAULT_START;
						state_q  <= S_CHECK;
					end
				end
				S_CHECK: begin
					total_q <= diff55[31:0];
					shift_q <= shift_d;
					spf_q   <= fatlc_pkg::SPF_W'(1);
					pass_q  <= '0;
					if (too_small || too_large) begin
						done_q   <= 1'b1;
						status_q <= too_small ? fatlc_pkg::ST_SMALL : fatlc_pkg::ST_LARGE;
						spc_q    <= '0;
						fat_q    <= '0;
						part_q   <= '0;
						dclus_q  <= '0;
						sstart_q <= '0;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_ITER;
					end
				end
				S_ITER: begin
					if (pres.meta_ovf) begin
						done_q   <= 1'b1;
						status_q <= fatlc_pkg::ST_SMALL;
						spc_q    <= '0;
						fat_q    <= '0;
						part_q   <= '0;
						dclus_q  <= '0;
						sstart_q <= '0;
						state_q  <= S_IDLE;
					end else begin
						clus_q <= pres.clusters;
						spf_q  <= pres.spf_next;
						pass_q <= pass_q + PASS_W'(1);
						if (pres.same || (pass_q == PASS_W'(MAX_PASSES - 1))) begin
							state_q <= S_FINAL;
						end
					end
				end
				S_FINAL: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (clus_q < fatlc_pkg::MIN_CLUSTERS || clus_q >= fatlc_pkg::MAX_CLUSTERS) begin
						status_q <= (clus_q < fatlc_pkg::MIN_CLUSTERS) ?
							fatlc_pkg::ST_SMALL : fatlc_pkg::ST_LARGE;
						spc_q    <= '0;
						fat_q    <= '0;
						part_q   <= '0;
						dclus_q  <= '0;
						sstart_q <= '0;
					end else begin
						status_q <= fatlc_pkg::ST_OK;
						spc_q    <= 7'(7'd1 << shift_q);
						fat_q    <= 32'(spf_q);
						part_q   <= total_q;
						dclus_q  <= clus_q;
						sstart_q <= start_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign status          = status_q;
	assign cluster_sectors = spc_q;
	assign fat_sectors     = fat_q;
	assign part_sectors    = part_q;
	assign cluster_count   = dclus_q;
	assign start_sector    = sstart_q;

endmodule
